/* hdl/cbba_pkg.sv */
// Package for the contiguous block bitmap allocator.
// Holds the map geometry, the command and status codes, the word types and the sequencer states.
// It depends on nothing else.
`default_nettype none

package cbba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W    = $clog2(NUM_BLOCKS);
  localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BYTES_W  = 23;
  localparam int FIELD_W  = 10;
  localparam int NEED_W   = BYTES_W + 1 - BB_SHIFT;
  localparam int CMP_W    = 24;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cbba_cmd_t;

  typedef enum logic [1:0] {
    RSP_OK      = 2'd0,
    RSP_NOSPACE = 2'd1,
    RSP_EMPTY   = 2'd2
  } cbba_status_t;

  typedef struct packed {
    cbba_cmd_t            cmd;
    logic [BYTES_W-1:0]   byte_count;
    logic [FIELD_W-1:0]   first_index;
    logic [FIELD_W-1:0]   last_index;
  } req_t;

  typedef struct packed {
    cbba_status_t         status;
    logic [FIELD_W-1:0]   run_first;
    logic [FIELD_W-1:0]   run_last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } cbba_state_t;

endpackage

`default_nettype wire

/* hdl/cbba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// It holds the block map; it uses no package.
`default_nettype none

module cbba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/cbba_ctrl.sv */
// Sequencer and shared index counter of the allocator, with the block map RAM.
// It clears the map, scans for free runs, and marks or frees ranges one block per cycle.
// It depends on cbba_pkg and cbba_ram.
`default_nettype none

module cbba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cbba_pkg::req_t req,
  output logic          done,
  input  logic          take,
  output cbba_pkg::rsp_t result
);
  import cbba_pkg::*;

  cbba_state_t        state, state_next;
  logic [IDX_W:0]     idx, idx_next;
  logic [IDX_W:0]     count, count_next;
  logic [IDX_W-1:0]   chk;
  logic               chk_v, chk_v_next;
  logic [IDX_W-1:0]   start, start_next;
  logic [IDX_W-1:0]   hi, hi_next;
  logic [NEED_W-1:0]  need, need_next;
  rsp_t               result_next;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic               ram_rdata;

  logic [BYTES_W:0]   byte_sum;
  logic [NEED_W-1:0]  need_calc;
  logic [CMP_W-1:0]   lo_ext;
  logic [CMP_W-1:0]   hi_ext;
  logic [CMP_W-1:0]   hi_clip;
  logic [IDX_W-1:0]   run_start;
  logic               hit;

  cbba_ram #(
    .WIDTH(1),
    .DEPTH(NUM_BLOCKS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign byte_sum  = {1'b0, req.byte_count} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign need_calc = byte_sum[BYTES_W:BB_SHIFT];
  assign lo_ext    = CMP_W'(req.first_index);
  assign hi_ext    = CMP_W'(req.last_index);
  assign hi_clip   = (hi_ext > CMP_W'(NUM_BLOCKS - 1)) ? CMP_W'(NUM_BLOCKS - 1) : hi_ext;
  assign run_start = (count == '0) ? chk : start;
  assign hit       = chk_v && !ram_rdata && (CMP_W'(count) + CMP_W'(1) == CMP_W'(need));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      chk_v <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      chk_v <= chk_v_next;
    end
    chk    <= idx[IDX_W-1:0];
    count  <= count_next;
    start  <= start_next;
    hi     <= hi_next;
    need   <= need_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    start_next  = start;
    hi_next     = hi;
    need_next   = need;
    result_next = result;
    chk_v_next  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx[IDX_W-1:0];
    ram_wdata   = 1'b0;
    ram_raddr   = idx[IDX_W-1:0];
    req_stall   = (state != S_IDLE);
    done        = (state == S_DONE);

    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx[IDX_W-1:0] == IDX_W'(NUM_BLOCKS - 1)) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          result_next = '{status: RSP_OK, run_first: '0, run_last: '0};
          if (req.cmd == CMD_FREE) begin
            if (lo_ext > hi_clip) begin
              state_next = S_DONE;
            end else begin
              idx_next   = (IDX_W + 1)'(lo_ext);
              hi_next    = IDX_W'(hi_clip);
              state_next = S_FREE;
            end
          end else begin
            need_next = need_calc;
            if (need_calc == '0) begin
              result_next.status = RSP_EMPTY;
              state_next         = S_DONE;
            end else if (CMP_W'(need_calc) > CMP_W'(NUM_BLOCKS)) begin
              result_next.status = RSP_NOSPACE;
              state_next         = S_DONE;
            end else begin
              idx_next   = '0;
              count_next = '0;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (!idx[IDX_W]) begin
          idx_next   = idx + 1'b1;
          chk_v_next = 1'b1;
        end
        if (chk_v) begin
          if (!ram_rdata) begin
            start_next = run_start;
            count_next = count + 1'b1;
          end else begin
            count_next = '0;
          end
        end
        if (hit) begin
          result_next.run_first = FIELD_W'(run_start);
          result_next.run_last  = FIELD_W'(chk);
          idx_next              = (IDX_W + 1)'(run_start);
          hi_next               = chk;
          chk_v_next            = 1'b0;
          state_next            = S_MARK;
        end else if (chk_v && chk == IDX_W'(NUM_BLOCKS - 1)) begin
          result_next.status = RSP_NOSPACE;
          chk_v_next         = 1'b0;
          state_next         = S_DONE;
        end
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        if (idx[IDX_W-1:0] == hi) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_FREE: begin
        ram_we = 1'b1;
        if (idx[IDX_W-1:0] == hi) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/contiguous_block_bitmap_allocator.sv */
// First-fit contiguous block allocator: top level with the result output register.
// After reset the map is cleared one block per cycle while req_stall stays high.
// An allocate scans the map for the first free run and then marks that run.
// A free clears its range; empty, oversized or reversed requests go straight to the result.
// One command is worked at a time; the block map RAM port and its shared index counter set it.
// It depends on cbba_pkg and cbba_ctrl.
`default_nettype none

module contiguous_block_bitmap_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cbba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cbba_pkg::rsp_t rsp
);
  import cbba_pkg::*;

  logic done;
  logic take;
  rsp_t result;

  cbba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .done     (done),
    .take     (take),
    .result   (result)
  );

  assign take = done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (take) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

/* hdl/cbba_chk.sv */
// Port-level checker for the allocator and the bind that attaches it to the top level.
// It depends on cbba_pkg and contiguous_block_bitmap_allocator.
`default_nettype none

module cbba_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cbba_pkg::rsp_t rsp
);
  import cbba_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("A stalled result word changed or vanished.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != RSP_OK |-> rsp.run_first == '0 && rsp.run_last == '0)
    else $error("A failed request reported a nonzero run.");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.run_first <= rsp.run_last)
    else $error("A reported run ends before it starts.");

  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> req_stall)
    else $error("A request word was taken during the map clear.");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("A second request word was taken before the first finished.");

endmodule

bind contiguous_block_bitmap_allocator cbba_chk u_cbba_chk (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire
